// ===== src/mpsp_pkg.sv =====
// Shared types and constants for the motor position/speed PID channel.
// No dependencies.
package mpsp_pkg;

  localparam int POS_W = 16;
  localparam int PER_W = 16;
  localparam int GAIN_W = 12;
  localparam int E_W = POS_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int Q_DEPTH = 2;

  localparam int FRAC_BITS_DEF = 6;
  localparam int INTEG_SAT_BITS_DEF = 15;
  localparam int OUT_SAT_BITS_DEF = 10;
  localparam int SPEED_SHIFT_DEF = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_POSITION = 3'd0,
    REG_SPEED_REF       = 3'd1,
    REG_GAIN_PROP       = 3'd2,
    REG_GAIN_INTEG      = 3'd3,
    REG_GAIN_DERIV      = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [E_W-1:0] err;
    logic [PER_W-1:0]      period;
    logic                  per_zero;
  } q_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] speed_ref;
    logic [GAIN_W-1:0]       kp;
    logic [GAIN_W-1:0]       ki;
    logic [GAIN_W-1:0]       kd;
  } loop_cfg_t;

endpackage

// ===== src/mpsp_front.sv =====
// Input side: takes a control tick, forms the position error and flags a zero period.
// Depends on mpsp_pkg.
module mpsp_front (
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [mpsp_pkg::POS_W-1:0] position_count,
  input  logic [mpsp_pkg::PER_W-1:0]      rotation_period,
  input  logic signed [mpsp_pkg::POS_W-1:0] target_position,
  input  logic                            q_full,
  output logic                            push,
  output mpsp_pkg::q_item_t               push_item
);
  import mpsp_pkg::*;

  assign in_stall = q_full;
  assign push = in_valid && !q_full;

  always_comb begin
    push_item.err = E_W'(target_position) - E_W'(position_count);
    push_item.period = rotation_period;
    push_item.per_zero = (rotation_period == '0);
  end

endmodule

// ===== src/mpsp_queue.sv =====
// Short FIFO between the front and back ends.
// Depends on mpsp_pkg.
module mpsp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mpsp_pkg::q_item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output mpsp_pkg::q_item_t pop_item
);
  import mpsp_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  q_item_t mem [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(Q_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !pop_valid))
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(Q_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ===== src/mpsp_div.sv =====
// Restoring divider, one quotient bit per cycle: (1 << SPEED_SHIFT) / divisor.
// Depends on mpsp_pkg.
module mpsp_div #(
  parameter int SPEED_SHIFT = mpsp_pkg::SPEED_SHIFT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mpsp_pkg::PER_W-1:0] divisor,
  output logic                       done,
  output logic [SPEED_SHIFT:0]       quotient
);
  import mpsp_pkg::*;

  localparam int SPD_W = SPEED_SHIFT + 1;
  localparam int CNT_W = $clog2(SPD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [SPD_W-1:0] num;
  logic [PER_W-1:0] rem;
  logic [PER_W-1:0] dvs;
  logic [PER_W:0]   trial;
  logic [PER_W:0]   trial_sub;
  logic             fits;

  always_comb begin
    trial = {rem, num[SPD_W-1]};
    fits = (trial >= {1'b0, dvs});
    trial_sub = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        num <= SPD_W'(1) << SPEED_SHIFT;
        rem <= '0;
        dvs <= divisor;
      end else if (busy) begin
        num <= num << 1;
        rem <= fits ? trial_sub[PER_W-1:0] : trial[PER_W-1:0];
        quotient <= {quotient[SPD_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SPD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/mpsp_back.sv =====
// Back end: speed division, integral update, drive sum and saturation, output register.
// Depends on mpsp_pkg and mpsp_div.
module mpsp_back #(
  parameter int FRAC_BITS      = mpsp_pkg::FRAC_BITS_DEF,
  parameter int INTEG_SAT_BITS = mpsp_pkg::INTEG_SAT_BITS_DEF,
  parameter int OUT_SAT_BITS   = mpsp_pkg::OUT_SAT_BITS_DEF,
  parameter int SPEED_SHIFT    = mpsp_pkg::SPEED_SHIFT_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  mpsp_pkg::q_item_t       q_item,
  output logic                    pop,
  input  mpsp_pkg::loop_cfg_t     cfg,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [OUT_SAT_BITS-1:0] drive_magnitude,
  output logic                    drive_forward
);
  import mpsp_pkg::*;

  localparam int SPD_W = SPEED_SHIFT + 1;
  localparam int DIFF_W = ((POS_W > SPD_W + 1) ? POS_W : SPD_W + 1) + 1;
  localparam int OPND_W = (E_W > DIFF_W) ? E_W : DIFF_W;
  localparam int PROD_W = GAIN_W + 1 + OPND_W;
  localparam int ACC_W = PROD_W + 2;
  localparam logic signed [PROD_W:0] I_HI = (PROD_W + 1)'((1 << (INTEG_SAT_BITS - 1)) - 1);
  localparam logic signed [PROD_W:0] I_LO = ~I_HI;
  localparam logic signed [ACC_W-1:0] O_HI = ACC_W'((1 << (OUT_SAT_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] O_LO = ~O_HI;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_MUL_I = 7'b0000100,
    S_INTEG = 7'b0001000,
    S_SUM_P = 7'b0010000,
    S_SUM_D = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic signed [E_W-1:0]            err;
  logic [SPD_W-1:0]                 speed;
  logic signed [INTEG_SAT_BITS-1:0] integral;
  logic signed [PROD_W-1:0]         mul_prod;
  logic signed [ACC_W-1:0]          acc;

  logic                     div_start;
  logic                     div_done;
  logic [SPD_W-1:0]         div_quo;
  logic signed [GAIN_W:0]   mul_a;
  logic signed [OPND_W-1:0] mul_b;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W:0]   isum;
  logic signed [PROD_W:0]   isat;
  logic signed [ACC_W-1:0]  acc_sh;
  logic signed [ACC_W-1:0]  osat;
  logic [OUT_SAT_BITS-1:0]  drive;
  logic                     out_load;

  mpsp_div #(
    .SPEED_SHIFT(SPEED_SHIFT)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .divisor(q_item.period),
    .done(div_done),
    .quotient(div_quo)
  );

  always_comb begin
    pop = (state == S_IDLE) && q_valid;
    div_start = pop && !q_item.per_zero;
    out_load = (state == S_OUT) && (!out_valid || !out_stall);

    diff = DIFF_W'($signed(cfg.speed_ref)) - DIFF_W'($signed({1'b0, speed}));

    case (state)
      S_MUL_I: begin
        mul_a = $signed({1'b0, cfg.ki});
        mul_b = OPND_W'(err);
      end
      S_INTEG: begin
        mul_a = $signed({1'b0, cfg.kp});
        mul_b = OPND_W'(err);
      end
      S_SUM_P: begin
        mul_a = $signed({1'b0, cfg.kd});
        mul_b = OPND_W'(diff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase

    isum = (PROD_W + 1)'(integral) + (PROD_W + 1)'(mul_prod >>> FRAC_BITS);
    if (isum > I_HI) begin
      isat = I_HI;
    end else if (isum < I_LO) begin
      isat = I_LO;
    end else begin
      isat = isum;
    end

    acc_sh = acc >>> FRAC_BITS;
    if (acc_sh > O_HI) begin
      osat = O_HI;
    end else if (acc_sh < O_LO) begin
      osat = O_LO;
    end else begin
      osat = acc_sh;
    end
    drive = osat[OUT_SAT_BITS-1:0];

    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          state_next = q_item.per_zero ? S_MUL_I : S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_MUL_I;
        end
      end
      S_MUL_I: state_next = S_INTEG;
      S_INTEG: state_next = S_SUM_P;
      S_SUM_P: state_next = S_SUM_D;
      S_SUM_D: state_next = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      integral <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_INTEG) begin
        integral <= isat[INTEG_SAT_BITS-1:0];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mul_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (pop) begin
      err <= q_item.err;
      if (q_item.per_zero) begin
        speed <= SPD_W'(1) << SPEED_SHIFT;
      end
    end
    if ((state == S_DIV) && div_done) begin
      speed <= div_quo;
    end
    if (state == S_SUM_P) begin
      acc <= ACC_W'(mul_prod) + ACC_W'(integral);
    end
    if (state == S_SUM_D) begin
      acc <= acc + ACC_W'(mul_prod);
    end
    if (out_load) begin
      drive_magnitude <= drive[OUT_SAT_BITS-1] ? -drive : drive;
      drive_forward <= !drive[OUT_SAT_BITS-1];
    end
  end

`ifndef SYNTHESIS
  a_pop_has_data: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("pop without queued item");
  a_div_done_state: assert property (@(posedge clk) disable iff (rst) div_done |-> state == S_DIV)
    else $error("divider finished outside divide state");
  a_load_shows: assert property (@(posedge clk) disable iff (rst) out_load |=> out_valid)
    else $error("result load did not raise out_valid");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) && out_valid && out_stall |=> state == S_OUT)
    else $error("result left the output state while blocked");
`endif

endmodule

// ===== src/motor_position_speed_pid.sv =====
// Top level of one motor channel of the position/speed PID controller.
// Depends on mpsp_pkg, mpsp_front, mpsp_queue, mpsp_back (and mpsp_div below it).
//
// Usage:
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data. Index 0 is the
//   target position, 1 the target speed, 2..4 the P, I and speed gains (12 bits,
//   6 fractional). cfg_ready is always high; unknown indexes are dropped.
//   Write configuration only while the channel is idle.
//   Input: one transfer per control tick on in_valid/in_stall carrying
//   position_count and rotation_period.
//   Output: one transfer per tick on out_valid/out_stall carrying drive_magnitude
//   and drive_forward.
//   Back end: the bit-serial speed divider sets how long an item takes in the back
//   end; a zero period skips the divider. A two-entry queue takes new ticks meanwhile.
//   Reset clears the integral, all configuration registers, the queue and out_valid.
//   While out_stall is high the result holds, the back end waits and the queue fills;
//   in_stall rises when the queue is full.
module motor_position_speed_pid #(
  parameter int FRAC_BITS      = mpsp_pkg::FRAC_BITS_DEF,
  parameter int INTEG_SAT_BITS = mpsp_pkg::INTEG_SAT_BITS_DEF,
  parameter int OUT_SAT_BITS   = mpsp_pkg::OUT_SAT_BITS_DEF,
  parameter int SPEED_SHIFT    = mpsp_pkg::SPEED_SHIFT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mpsp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mpsp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [mpsp_pkg::POS_W-1:0]  position_count,
  input  logic [mpsp_pkg::PER_W-1:0]         rotation_period,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [OUT_SAT_BITS-1:0]            drive_magnitude,
  output logic                               drive_forward
);
  import mpsp_pkg::*;

  logic signed [POS_W-1:0] target_position;
  loop_cfg_t               cfg;
  logic                    push;
  q_item_t                 push_item;
  logic                    q_full;
  logic                    pop;
  logic                    q_valid;
  q_item_t                 q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_position <= '0;
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TARGET_POSITION: target_position <= $signed(cfg_data[POS_W-1:0]);
        REG_SPEED_REF:       cfg.speed_ref <= $signed(cfg_data[POS_W-1:0]);
        REG_GAIN_PROP:       cfg.kp <= cfg_data[GAIN_W-1:0];
        REG_GAIN_INTEG:      cfg.ki <= cfg_data[GAIN_W-1:0];
        REG_GAIN_DERIV:      cfg.kd <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  mpsp_front u_front (
    .in_valid(in_valid),
    .in_stall(in_stall),
    .position_count(position_count),
    .rotation_period(rotation_period),
    .target_position(target_position),
    .q_full(q_full),
    .push(push),
    .push_item(push_item)
  );

  mpsp_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_item(push_item),
    .full(q_full),
    .pop(pop),
    .pop_valid(q_valid),
    .pop_item(q_item)
  );

  mpsp_back #(
    .FRAC_BITS(FRAC_BITS),
    .INTEG_SAT_BITS(INTEG_SAT_BITS),
    .OUT_SAT_BITS(OUT_SAT_BITS),
    .SPEED_SHIFT(SPEED_SHIFT)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_item(q_item),
    .pop(pop),
    .cfg(cfg),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .drive_magnitude(drive_magnitude),
    .drive_forward(drive_forward)
  );

endmodule

// ===== tb/sv/tb_motor_position_speed_pid.sv =====
// Self-checking testbench for one motor_position_speed_pid channel.
// Needs mpsp_pkg and the block's RTL. A scoreboard class predicts each drive transfer
// from the position ticks and register writes, and checks every result in order.
module tb_motor_position_speed_pid;
  timeunit 1ns;
  timeprecision 1ps;
  import mpsp_pkg::*;

  localparam int CLK_HALF = 5;
  localparam int MAG_W = OUT_SAT_BITS_DEF;
  localparam int IDLE_PCT = 12;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 65;
  localparam int QUIET_PHASE = 3;
  localparam int HOLD_PHASE = 5;
  localparam longint CYCLE_LIMIT = 300000;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LAST = 3'd7;
  localparam logic signed [POS_W-1:0] POS_MIN = 16'sh8000;
  localparam logic signed [POS_W-1:0] POS_MAX = 16'sh7FFF;
  localparam logic [PER_W-1:0] PER_MAX = 16'hFFFF;
  localparam logic [GAIN_W-1:0] GAIN_MAX = 12'hFFF;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             fwd;
  } drive_t;

  class drive_scoreboard;
    logic signed [POS_W-1:0] tgt_pos = '0;
    logic signed [POS_W-1:0] tgt_speed = '0;
    logic [GAIN_W-1:0] kp = '0;
    logic [GAIN_W-1:0] ki = '0;
    logic [GAIN_W-1:0] kd = '0;
    longint integ = 0;
    drive_t expected_drives[$];
    int errors = 0;

    function longint clip(longint v, int bits);
      longint lim;
      lim = longint'(1) << (bits - 1);
      if (v > lim - 1) return lim - 1;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TARGET_POSITION: tgt_pos = data;
        REG_SPEED_REF:       tgt_speed = data;
        REG_GAIN_PROP:       kp = data[GAIN_W-1:0];
        REG_GAIN_INTEG:      ki = data[GAIN_W-1:0];
        REG_GAIN_DERIV:      kd = data[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_tick(logic signed [POS_W-1:0] pos, logic [PER_W-1:0] per);
      longint speed, err, drive;
      drive_t d;
      if (per == 0) speed = longint'(1) << SPEED_SHIFT_DEF;
      else speed = (longint'(1) << SPEED_SHIFT_DEF) / longint'(per);
      err = longint'(tgt_pos) - longint'(pos);
      integ = clip(integ + ((longint'(ki) * err) >>> FRAC_BITS_DEF), INTEG_SAT_BITS_DEF);
      drive = longint'(kp) * err + integ + longint'(kd) * (longint'(tgt_speed) - speed);
      drive = clip(drive >>> FRAC_BITS_DEF, OUT_SAT_BITS_DEF);
      d.mag = MAG_W'(drive < 0 ? -drive : drive);
      d.fwd = (drive >= 0);
      expected_drives.push_back(d);
    endfunction

    function void check_drive(logic [MAG_W-1:0] mag, logic fwd);
      drive_t d;
      if (expected_drives.size() == 0) begin
        errors++;
        $display("%0t: unexpected drive transfer, magnitude %0d forward %0b", $time, mag, fwd);
        return;
      end
      d = expected_drives.pop_front();
      if (mag !== d.mag) begin
        errors++;
        $display("%0t: drive_magnitude expected %0d actual %0d", $time, d.mag, mag);
      end
      if (fwd !== d.fwd) begin
        errors++;
        $display("%0t: drive_forward expected %0b actual %0b", $time, d.fwd, fwd);
      end
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [POS_W-1:0] position_count = '0;
  logic [PER_W-1:0] rotation_period = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [MAG_W-1:0] drive_magnitude;
  logic drive_forward;

  drive_scoreboard sb = new;
  bit idle_on = 1'b1;
  bit hold_request = 1'b0;
  int hold_left = 0;
  longint cycles = 0;

  motor_position_speed_pid i_dut (.*);

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_drive(drive_magnitude, drive_forward);
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic load_config(logic signed [POS_W-1:0] tp, logic signed [POS_W-1:0] ts,
                             logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
                             logic [GAIN_W-1:0] kd);
    write_reg(REG_TARGET_POSITION, tp);
    write_reg(REG_SPEED_REF, ts);
    write_reg(REG_GAIN_PROP, {4'($urandom), kp});
    write_reg(REG_GAIN_INTEG, {4'($urandom), ki});
    write_reg(REG_GAIN_DERIV, {4'($urandom), kd});
    // unused index, must be dropped
    write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_SPARE_FIRST, CFG_IDX_SPARE_LAST)),
              CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_tick(logic signed [POS_W-1:0] pos, logic [PER_W-1:0] per);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      position_count <= POS_W'($urandom);
      rotation_period <= PER_W'($urandom);
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
    in_valid <= 1'b1;
    position_count <= pos;
    rotation_period <= per;
    do @(posedge clk); while (in_stall);
    sb.note_tick(pos, per);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(9))
      0: return '0;
      1: return GAIN_MAX;
      2, 3, 4, 5, 6: return GAIN_W'($urandom_range(0, 127));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [POS_W-1:0] tp, ts, pos;
    logic [PER_W-1:0] per;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // all-zero registers: drive is zero, forward set
    send_tick(16'sd0, 16'd0);
    send_tick(POS_MIN, PER_MAX);
    send_tick(POS_MAX, 16'd1);
    drain();

    // max gains, integral runs to positive saturation
    load_config(POS_MAX, POS_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
    send_tick(POS_MIN, 16'd0);
    send_tick(POS_MIN, PER_MAX);
    send_tick(POS_MAX, 16'd1);
    drain();

    // negative saturation, most negative drive
    load_config(POS_MIN, POS_MIN, GAIN_MAX, GAIN_MAX, GAIN_MAX);
    send_tick(POS_MAX, 16'd0);
    send_tick(POS_MAX, 16'd1);
    send_tick(POS_MIN, 16'd2);
    drain();

    // small errors, rounding of negative shifts
    load_config(16'sd0, 16'sd0, 12'd64, 12'd1, 12'd0);
    send_tick(16'sd1, 16'd1);
    send_tick(-16'sd1, 16'd1);
    send_tick(16'sd100, 16'h8000);
    send_tick(-16'sd300, 16'd3);
    send_tick(16'sd0, 16'd0);
    drain();

    // speed term across the period range
    load_config(16'sd0, 16'sd1, 12'd0, 12'd0, 12'd64);
    send_tick(16'sd0, 16'd0);
    send_tick(16'sd0, 16'd1);
    send_tick(16'sd0, 16'd2);
    send_tick(16'sd0, PER_MAX);
    send_tick(16'sd0, 16'h8000);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(3))
        0: tp = POS_MIN;
        1: tp = POS_MAX;
        default: tp = POS_W'($urandom);
      endcase
      if ($urandom_range(3) == 0) ts = POS_W'($urandom);
      else ts = POS_W'($urandom_range(0, 6000)) - 16'sd3000;
      load_config(tp, ts, pick_gain(), pick_gain(), pick_gain());
      idle_on = (ph != QUIET_PHASE);
      if (ph == HOLD_PHASE) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: pos = tp + POS_W'($urandom_range(0, 400)) - 16'sd200;
          5, 6, 7: pos = POS_W'($urandom);
          default: begin
            case ($urandom_range(3))
              0: pos = POS_MIN;
              1: pos = POS_MAX;
              2: pos = 16'sd0;
              default: pos = -16'sd1;
            endcase
          end
        endcase
        case ($urandom_range(9))
          0: per = '0;
          1: per = PER_MAX;
          2, 3, 4: per = PER_W'($urandom_range(1, 64));
          default: per = PER_W'($urandom);
        endcase
        send_tick(pos, per);
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
